@@ hdl/lrct_pkg.sv @@
`default_nettype none

package lrct_pkg;

    localparam int LAYERS_DEF          = 8;
    localparam int LATES_PER_LAYER_DEF = 16;
    localparam int LOSS_SLOTS_DEF      = 32;

    localparam logic [7:0]  CHECK_VALUE = 8'h55;
    localparam logic [15:0] LATE_TIMEOUT_RST = 16'd500;
    localparam logic [15:0] DEAF_PERIOD_RST  = 16'd10000;
    localparam logic [15:0] LOSSES_ACC_RST   = 16'd0;
    localparam logic [15:0] LATES_ACC_RST    = 16'd0;
    localparam logic [5:0]  LOSS_LIMIT_RST   = 6'd5;
    localparam logic [15:0] LOSS_WINDOW_RST  = 16'd500;

    localparam logic [15:0]        SINCE_MAX = 16'hFFFF;
    localparam logic signed [16:0] LATES_MAX = 17'sh0FFFF;
    localparam logic signed [16:0] LATES_MIN = 17'sh10000;

    localparam int LATE_WORD_W = 48;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_DEAF = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CFG_LATE_TIMEOUT = 3'd0,
        CFG_DEAF_PERIOD  = 3'd1,
        CFG_LOSSES_ACC   = 3'd2,
        CFG_LATES_ACC    = 3'd3,
        CFG_LOSS_LIMIT   = 3'd4,
        CFG_LOSS_WINDOW  = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AGE,
        S_EXP_RD,
        S_EXP_EV,
        S_LOSS_FIND,
        S_DEAF,
        S_REM_RD,
        S_REM_EV,
        S_REM_FIN,
        S_GAP,
        S_JOIN,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

@@ hdl/layered_receiver_congestion_tracker_core.sv @@
`default_nettype none

// Receiver-side layered congestion tracker. Each header word arrives on the
// input channel (i_in_valid / o_in_stall) and yields exactly one result word
// on the output channel (o_out_valid / i_out_stall). Configuration registers
// are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user must write
// them only while the block is idle, which the block does not enforce itself.
// One header is worked on at a time by a small sequencer. A rejected header
// goes straight to its result. A valid header ages the loss window, visits
// each late slot of the joined layers to expire old entries, seeks a free loss
// slot for each new loss, and then either looks up a late arrival or records a
// gap where needed. The late store sits in one memory with a registered read,
// so each used late slot is visited in a read state and an evaluation state.
// Reset restores the register defaults and empties all lists; no clearing pass
// is needed. While the receiver stalls, the finished result is held and the
// next header may still be processed up to its result, where it waits.

module layered_receiver_congestion_tracker_core
    import lrct_pkg::*;
#(
    parameter int LAYERS          = LAYERS_DEF,
    parameter int LATES_PER_LAYER = LATES_PER_LAYER_DEF,
    parameter int LOSS_SLOTS      = LOSS_SLOTS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [7:0]  i_check_byte,
    input  wire  [7:0]  i_layer_index,
    input  wire  [15:0] i_seq_number,
    input  wire         i_sync_point,
    input  wire  [3:0]  i_layers_joined,
    input  wire  [31:0] i_now_ms,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [1:0]  o_status,
    output logic        o_join_request,
    output logic        o_drop_request,
    output logic [5:0]  o_losses_in_window,
    output logic [7:0]  o_lates_pending,
    output logic        o_late_overflow,
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_idx,
    input  wire  [15:0] i_cfg_data
);

    localparam int LATE_SLOTS = LAYERS * LATES_PER_LAYER;
    localparam int AW  = $clog2(LATE_SLOTS);
    localparam int IW  = $clog2(LATE_SLOTS + 1);
    localparam int KW  = $clog2(LATES_PER_LAYER + 1);
    localparam int LW  = $clog2(LAYERS);
    localparam int LCW = $clog2(LOSS_SLOTS + 1);
    localparam int LIW = (LOSS_SLOTS > 1) ? $clog2(LOSS_SLOTS) : 1;

    t_state r_state, n_state;

    logic [15:0] r_late_to, r_deaf_per, r_loss_acc, r_late_acc, r_win;
    logic [5:0]  r_loss_lim;

    logic [LW-1:0] r_layer, n_layer;
    logic [7:0]    r_layer8, n_layer8;
    logic [15:0]   r_seq, n_seq;
    logic          r_sp, n_sp;
    logic [3:0]    r_joined, n_joined;
    logic [31:0]   r_now, n_now;

    logic [15:0]           r_exp_seq [LAYERS];
    logic [LAYERS-1:0]     r_first, n_first;
    logic [LATE_SLOTS-1:0] r_late_valid, n_late_valid;
    logic [LOSS_SLOTS-1:0] r_loss_valid, n_loss_valid;
    logic [15:0]           r_loss_cd [LOSS_SLOTS];

    logic [LCW-1:0]     r_loss_count, n_loss_count;
    logic [IW-1:0]      r_late_count, n_late_count;
    logic [15:0]        r_loss_since, n_loss_since;
    logic signed [16:0] r_lates_since, n_lates_since;
    logic [31:0]        r_deaf_until, n_deaf_until;
    logic               r_deaf_active, n_deaf_active;

    logic [IW-1:0]  r_i, n_i;
    logic [LCW-1:0] r_j, n_j;
    logic [KW-1:0]  r_k, n_k;
    logic [15:0]    r_s, n_s;
    logic [AW-1:0]  r_addr, n_addr;
    logic           r_found, n_found;
    logic [AW-1:0]  r_best, n_best;
    logic [31:0]    r_bestd, n_bestd;

    logic [1:0] r_status, n_status;
    logic       r_join, n_join, r_drop, n_drop, r_ovf, n_ovf;

    logic       r_o_valid, n_o_valid;
    logic [1:0] r_o_status;
    logic       r_o_join, r_o_drop, r_o_ovf;
    logic [5:0] r_o_losses;
    logic [7:0] r_o_lates;
    logic       load_out;

    logic        es_we;
    logic [15:0] es_val;
    logic        cd_we;
    logic [LIW-1:0] cd_idx;
    logic [15:0] cd_val;
    logic        mw_we;
    logic [AW-1:0] w_raddr;
    logic [LATE_WORD_W-1:0] mw_data, mem_q;

    logic [AW-1:0] w_base, w_kaddr;
    logic [IW-1:0] w_lim;
    logic [LIW-1:0] w_jidx;
    logic [15:0]   w_q_seq, w_cd_dec, w_exp_cur;
    logic [31:0]   w_q_exp, w_d;
    logic [16:0]   w_gd;
    logic          w_gap, w_still_deaf;

    assign w_base  = AW'(32'(r_layer) * LATES_PER_LAYER);
    assign w_kaddr = w_base + AW'(r_k);
    assign w_lim   = (32'(r_joined) < LAYERS) ?
                     IW'(32'(r_joined) * LATES_PER_LAYER) : IW'(LATE_SLOTS);
    assign w_jidx  = r_j[LIW-1:0];
    assign w_q_seq = mem_q[47:32];
    assign w_q_exp = mem_q[31:0];
    assign w_d     = w_q_exp - r_now;
    assign w_cd_dec  = r_loss_cd[w_jidx] - 16'd1;
    assign w_exp_cur = r_exp_seq[r_layer];
    assign w_raddr   = (r_state == S_REM_RD) ? w_kaddr : r_i[AW-1:0];
    assign mw_data   = {r_s, r_now + {16'd0, r_late_to}};
    assign w_still_deaf = r_deaf_active && ((r_now - r_deaf_until) >> 31) == 32'd1;

    always_comb begin
        if (w_exp_cur < r_seq) begin
            w_gd  = 17'(r_seq - w_exp_cur);
            w_gap = w_gd < (17'd65535 - w_gd);
        end else begin
            w_gd  = 17'(w_exp_cur - r_seq);
            w_gap = !(w_gd < (17'd65535 - w_gd));
        end
    end

    lrct_late_mem #(
        .DEPTH(LATE_SLOTS),
        .AW   (AW)
    ) u_late_mem (
        .i_clk  (i_clk),
        .i_we   (mw_we),
        .i_waddr(w_kaddr),
        .i_wdata(mw_data),
        .i_raddr(w_raddr),
        .o_rdata(mem_q)
    );

    always_comb begin
        n_state = r_state;
        n_layer = r_layer; n_layer8 = r_layer8; n_seq = r_seq; n_sp = r_sp;
        n_joined = r_joined; n_now = r_now;
        n_first = r_first; n_late_valid = r_late_valid; n_loss_valid = r_loss_valid;
        n_loss_count = r_loss_count; n_late_count = r_late_count;
        n_loss_since = r_loss_since; n_lates_since = r_lates_since;
        n_deaf_until = r_deaf_until; n_deaf_active = r_deaf_active;
        n_i = r_i; n_j = r_j; n_k = r_k; n_s = r_s; n_addr = r_addr;
        n_found = r_found; n_best = r_best; n_bestd = r_bestd;
        n_status = r_status; n_join = r_join; n_drop = r_drop; n_ovf = r_ovf;
        n_o_valid = r_o_valid && i_out_stall;
        load_out = 1'b0;
        es_we = 1'b0; es_val = r_seq + 16'd1;
        cd_we = 1'b0; cd_idx = w_jidx; cd_val = w_cd_dec;
        mw_we = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_layer  = LW'(i_layer_index);
                    n_layer8 = i_layer_index;
                    n_seq    = i_seq_number;
                    n_sp     = i_sync_point;
                    n_joined = i_layers_joined;
                    n_now    = i_now_ms;
                    n_join = 1'b0; n_drop = 1'b0; n_ovf = 1'b0;
                    n_j = '0;
                    if (i_check_byte != CHECK_VALUE ||
                        i_layer_index >= 8'(i_layers_joined) ||
                        32'(i_layer_index) >= LAYERS) begin
                        n_status = ST_BAD;
                        n_state  = S_DONE;
                    end else begin
                        n_status = ST_OK;
                        n_state  = S_AGE;
                    end
                end
            end
            S_AGE: begin
                if (r_j == LCW'(LOSS_SLOTS)) begin
                    n_i = '0;
                    n_state = S_EXP_RD;
                end else begin
                    if (r_loss_valid[w_jidx]) begin
                        cd_we = 1'b1;
                        if (w_cd_dec == 16'd0) begin
                            n_loss_valid[w_jidx] = 1'b0;
                            if (r_loss_count != '0) begin
                                n_loss_count = r_loss_count - LCW'(1);
                            end
                        end
                    end
                    n_j = r_j + LCW'(1);
                end
            end
            S_EXP_RD: begin
                if (r_i >= w_lim) begin
                    n_state = S_DEAF;
                end else if (!r_late_valid[r_i[AW-1:0]]) begin
                    n_i = r_i + IW'(1);
                end else begin
                    n_addr  = r_i[AW-1:0];
                    n_state = S_EXP_EV;
                end
            end
            S_EXP_EV: begin
                if (((r_now - w_q_exp) >> 31) == 32'd0) begin
                    n_late_valid[r_addr] = 1'b0;
                    if (r_late_count != '0) begin
                        n_late_count = r_late_count - IW'(1);
                    end
                    if (r_lates_since != LATES_MIN) begin
                        n_lates_since = r_lates_since - 17'sd1;
                    end
                    if (r_loss_since != SINCE_MAX) begin
                        n_loss_since = r_loss_since + 16'd1;
                    end
                    if (32'(r_loss_count) + 32'd1 >= 32'(r_loss_lim)) begin
                        n_late_valid  = '0;
                        n_loss_valid  = '0;
                        n_loss_count  = '0;
                        n_late_count  = '0;
                        n_loss_since  = '0;
                        n_lates_since = '0;
                        if (32'(r_joined) <= LAYERS) begin
                            n_first[LW'(r_joined - 4'd1)] = 1'b1;
                        end
                        n_deaf_until  = r_now + {16'd0, r_deaf_per};
                        n_deaf_active = 1'b1;
                        n_drop  = 1'b1;
                        n_state = S_DEAF;
                    end else begin
                        n_j = '0;
                        n_state = S_LOSS_FIND;
                    end
                end else begin
                    n_i = r_i + IW'(1);
                    n_state = S_EXP_RD;
                end
            end
            S_LOSS_FIND: begin
                if (r_j == LCW'(LOSS_SLOTS)) begin
                    n_i = r_i + IW'(1);
                    n_state = S_EXP_RD;
                end else if (!r_loss_valid[w_jidx]) begin
                    n_loss_valid[w_jidx] = 1'b1;
                    cd_we  = 1'b1;
                    cd_val = r_win;
                    n_loss_count = r_loss_count + LCW'(1);
                    n_i = r_i + IW'(1);
                    n_state = S_EXP_RD;
                end else begin
                    n_j = r_j + LCW'(1);
                end
            end
            S_DEAF: begin
                n_deaf_active = w_still_deaf;
                n_k = '0;
                n_found = 1'b0;
                n_bestd = '0;
                if (w_still_deaf) begin
                    es_we = 1'b1;
                    n_status = ST_DEAF;
                    n_state  = S_DONE;
                end else if (r_first[r_layer]) begin
                    es_we = 1'b1;
                    n_first[r_layer] = 1'b0;
                    n_state = S_JOIN;
                end else if (w_exp_cur == r_seq) begin
                    es_we = 1'b1;
                    n_state = S_JOIN;
                end else if (w_gap) begin
                    n_s = w_exp_cur;
                    n_state = S_GAP;
                end else begin
                    n_state = S_REM_RD;
                end
            end
            S_GAP: begin
                if (r_s == r_seq) begin
                    es_we = 1'b1;
                    n_state = S_JOIN;
                end else if (r_k == KW'(LATES_PER_LAYER)) begin
                    n_ovf = 1'b1;
                    es_we = 1'b1;
                    n_state = S_JOIN;
                end else begin
                    if (!r_late_valid[w_kaddr]) begin
                        mw_we = 1'b1;
                        n_late_valid[w_kaddr] = 1'b1;
                        n_late_count = r_late_count + IW'(1);
                        if (r_lates_since != LATES_MAX) begin
                            n_lates_since = r_lates_since + 17'sd1;
                        end
                        n_s = r_s + 16'd1;
                    end
                    n_k = r_k + KW'(1);
                end
            end
            S_REM_RD: begin
                if (r_k == KW'(LATES_PER_LAYER)) begin
                    n_state = S_REM_FIN;
                end else begin
                    n_addr  = w_kaddr;
                    n_state = S_REM_EV;
                end
            end
            S_REM_EV: begin
                if (r_late_valid[r_addr] && w_q_seq == r_seq) begin
                    if (!r_found || w_d > r_bestd) begin
                        n_found = 1'b1;
                        n_best  = r_addr;
                        n_bestd = w_d;
                    end
                end
                n_k = r_k + KW'(1);
                n_state = S_REM_RD;
            end
            S_REM_FIN: begin
                if (r_found) begin
                    n_late_valid[r_best] = 1'b0;
                    if (r_late_count != '0) begin
                        n_late_count = r_late_count - IW'(1);
                    end
                    if (r_lates_since != LATES_MIN) begin
                        n_lates_since = r_lates_since - 17'sd1;
                    end
                end
                n_state = S_JOIN;
            end
            S_JOIN: begin
                if (r_sp && r_layer8 == 8'(r_joined - 4'd1) &&
                    r_loss_since <= r_loss_acc &&
                    r_lates_since <= $signed({1'b0, r_late_acc})) begin
                    n_join = 1'b1;
                    n_loss_since  = '0;
                    n_lates_since = '0;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_o_valid || !i_out_stall) begin
                    load_out  = 1'b1;
                    n_o_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_first       <= '1;
            r_late_valid  <= '0;
            r_loss_valid  <= '0;
            r_loss_count  <= '0;
            r_late_count  <= '0;
            r_loss_since  <= '0;
            r_lates_since <= '0;
            r_deaf_until  <= '0;
            r_deaf_active <= 1'b0;
            r_o_valid     <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_first       <= n_first;
            r_late_valid  <= n_late_valid;
            r_loss_valid  <= n_loss_valid;
            r_loss_count  <= n_loss_count;
            r_late_count  <= n_late_count;
            r_loss_since  <= n_loss_since;
            r_lates_since <= n_lates_since;
            r_deaf_until  <= n_deaf_until;
            r_deaf_active <= n_deaf_active;
            r_o_valid     <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LAYERS; l++) begin
                r_exp_seq[l] <= '0;
            end
        end else if (es_we) begin
            r_exp_seq[r_layer] <= es_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_late_to  <= LATE_TIMEOUT_RST;
            r_deaf_per <= DEAF_PERIOD_RST;
            r_loss_acc <= LOSSES_ACC_RST;
            r_late_acc <= LATES_ACC_RST;
            r_loss_lim <= LOSS_LIMIT_RST;
            r_win      <= LOSS_WINDOW_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LATE_TIMEOUT: r_late_to  <= i_cfg_data;
                CFG_DEAF_PERIOD:  r_deaf_per <= i_cfg_data;
                CFG_LOSSES_ACC:   r_loss_acc <= i_cfg_data;
                CFG_LATES_ACC:    r_late_acc <= i_cfg_data;
                CFG_LOSS_LIMIT:   r_loss_lim <= i_cfg_data[5:0];
                CFG_LOSS_WINDOW:  r_win      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (cd_we) begin
            r_loss_cd[cd_idx] <= cd_val;
        end
        r_layer  <= n_layer;
        r_layer8 <= n_layer8;
        r_seq    <= n_seq;
        r_sp     <= n_sp;
        r_joined <= n_joined;
        r_now    <= n_now;
        r_i      <= n_i;
        r_j      <= n_j;
        r_k      <= n_k;
        r_s      <= n_s;
        r_addr   <= n_addr;
        r_found  <= n_found;
        r_best   <= n_best;
        r_bestd  <= n_bestd;
        r_status <= n_status;
        r_join   <= n_join;
        r_drop   <= n_drop;
        r_ovf    <= n_ovf;
        if (load_out) begin
            r_o_status <= r_status;
            r_o_join   <= r_join;
            r_o_drop   <= r_drop;
            r_o_ovf    <= r_ovf;
            r_o_losses <= 6'(r_loss_count);
            r_o_lates  <= 8'(r_late_count);
        end
    end

    assign o_in_stall         = (r_state != S_IDLE);
    assign o_out_valid        = r_o_valid;
    assign o_status           = r_o_status;
    assign o_join_request     = r_o_join;
    assign o_drop_request     = r_o_drop;
    assign o_losses_in_window = r_o_losses;
    assign o_lates_pending    = r_o_lates;
    assign o_late_overflow    = r_o_ovf;

    a_late_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_late_count) == $countones(r_late_valid))
        else $error("late count differs from the number of held entries");

    a_loss_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_loss_count) == $countones(r_loss_valid))
        else $error("loss count differs from the number of held losses");

    a_drop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_drop_request |-> o_losses_in_window == 6'd0)
        else $error("drop word reports losses left in the window");

    a_join_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_join_request |-> o_status == ST_OK)
        else $error("join requested on a word that was not processed");

endmodule

`default_nettype wire

@@ hdl/lrct_late_mem.sv @@
`default_nettype none

module lrct_late_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  wire                                i_clk,
    input  wire                                i_we,
    input  wire  [AW-1:0]                      i_waddr,
    input  wire  [lrct_pkg::LATE_WORD_W-1:0]   i_wdata,
    input  wire  [AW-1:0]                      i_raddr,
    output logic [lrct_pkg::LATE_WORD_W-1:0]   o_rdata
);
    import lrct_pkg::*;

    logic [LATE_WORD_W-1:0] r_mem [DEPTH];
    logic [LATE_WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ sim/lrct_header_checker.sv @@
`timescale 1ns / 100ps

module lrct_header_checker
    import lrct_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    input  wire         i_in_stall,
    input  wire  [7:0]  i_check_byte,
    input  wire  [7:0]  i_layer_index,
    input  wire  [15:0] i_seq_number,
    input  wire         i_sync_point,
    input  wire  [3:0]  i_layers_joined,
    input  wire  [31:0] i_now_ms,
    input  wire         i_out_valid,
    input  wire         i_out_stall,
    input  wire  [1:0]  i_status,
    input  wire         i_join_request,
    input  wire         i_drop_request,
    input  wire  [5:0]  i_losses_in_window,
    input  wire  [7:0]  i_lates_pending,
    input  wire         i_late_overflow,
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_idx,
    input  wire  [15:0] i_cfg_data,
    output int          o_pending,
    output int          o_errors
);

    localparam int NL   = LAYERS_DEF;
    localparam int NPL  = LATES_PER_LAYER_DEF;
    localparam int NLS  = LOSS_SLOTS_DEF;

    typedef struct packed {
        logic [1:0] status;
        logic       join_req;
        logic       drop_req;
        logic [5:0] losses;
        logic [7:0] lates;
        logic       ovf;
    } t_verdict;

    t_verdict expected_results[$];

    logic [15:0] timeout_ms, deaf_ms, losses_ok, lates_ok, window_pkts;
    logic [5:0]  limit;

    logic [15:0] next_seq [NL];
    bit          awaiting_first [NL];
    logic [15:0] gap_seq [NL*NPL];
    logic [31:0] gap_deadline [NL*NPL];
    bit          gap_held [NL*NPL];
    logic [15:0] loss_left [NLS];
    bit          loss_held [NLS];
    int          loss_total, late_total, losses_since, lates_since;
    logic [31:0] deaf_end;
    bit          deaf_on;

    function automatic void empty_lists();
        for (int i = 0; i < NL*NPL; i++) gap_held[i] = 0;
        for (int k = 0; k < NLS; k++) loss_held[k] = 0;
        loss_total = 0;
        late_total = 0;
        losses_since = 0;
        lates_since = 0;
    endfunction

    function automatic void restart();
        timeout_ms = LATE_TIMEOUT_RST;
        deaf_ms = DEAF_PERIOD_RST;
        losses_ok = LOSSES_ACC_RST;
        lates_ok = LATES_ACC_RST;
        limit = LOSS_LIMIT_RST;
        window_pkts = LOSS_WINDOW_RST;
        for (int l = 0; l < NL; l++) begin
            next_seq[l] = '0;
            awaiting_first[l] = 1;
        end
        empty_lists();
        deaf_end = '0;
        deaf_on = 0;
    endfunction

    function automatic void late_down();
        if (lates_since > -65536) lates_since--;
    endfunction

    // Returns one when the new loss forces the top layer to be dropped.
    function automatic bit note_loss(logic [31:0] now, int joined);
        bit stored;
        stored = 0;
        if (losses_since < 65535) losses_since++;
        if (loss_total + 1 >= int'(limit)) begin
            empty_lists();
            if (joined >= 1 && joined - 1 < NL) awaiting_first[joined-1] = 1;
            deaf_end = now + {16'd0, deaf_ms};
            deaf_on = 1;
            return 1;
        end
        for (int k = 0; k < NLS; k++) begin
            if (!stored && !loss_held[k]) begin
                loss_held[k] = 1;
                loss_left[k] = window_pkts;
                loss_total++;
                stored = 1;
            end
        end
        return 0;
    endfunction

    function automatic t_verdict predict_header(logic [7:0] chk, logic [7:0] layer,
                                                logic [15:0] seq, logic sp,
                                                logic [3:0] joined, logic [31:0] now);
        t_verdict r;
        logic [31:0] diff, best_d;
        int nb, base, best, w, s, d, k;
        bit found, isgap, dropped;
        r = '0;
        dropped = 0;
        if (chk != CHECK_VALUE || layer >= joined || layer >= NL) begin
            r.status = ST_BAD;
        end else begin
            for (k = 0; k < NLS; k++) begin
                if (loss_held[k]) begin
                    loss_left[k] = loss_left[k] - 16'd1;
                    if (loss_left[k] == 16'd0) begin
                        loss_held[k] = 0;
                        if (loss_total > 0) loss_total--;
                    end
                end
            end
            nb = (joined < NL) ? int'(joined) : NL;
            for (int i = 0; i < nb*NPL; i++) begin
                diff = now - gap_deadline[i];
                if (!dropped && gap_held[i] && !diff[31]) begin
                    gap_held[i] = 0;
                    if (late_total > 0) late_total--;
                    late_down();
                    if (note_loss(now, int'(joined))) dropped = 1;
                end
            end
            r.drop_req = dropped;
            diff = now - deaf_end;
            if (deaf_on && !diff[31]) deaf_on = 0;
            if (deaf_on) begin
                next_seq[layer] = seq + 16'd1;
                r.status = ST_DEAF;
            end else begin
                r.status = ST_OK;
                base = int'(layer) * NPL;
                if (awaiting_first[layer]) begin
                    next_seq[layer] = seq + 16'd1;
                    awaiting_first[layer] = 0;
                end else if (next_seq[layer] == seq) begin
                    next_seq[layer] = seq + 16'd1;
                end else begin
                    w = int'(next_seq[layer]);
                    s = int'(seq);
                    if (w < s) begin
                        d = s - w;
                        isgap = d < 65535 - d;
                    end else begin
                        d = w - s;
                        isgap = !(d < 65535 - d);
                    end
                    if (isgap) begin
                        k = 0;
                        while (next_seq[layer] != seq && !r.ovf) begin
                            while (k < NPL && gap_held[base+k]) k++;
                            if (k >= NPL) begin
                                r.ovf = 1;
                            end else begin
                                gap_held[base+k] = 1;
                                gap_seq[base+k] = next_seq[layer];
                                gap_deadline[base+k] = now + {16'd0, timeout_ms};
                                late_total++;
                                if (lates_since < 65535) lates_since++;
                                next_seq[layer] = next_seq[layer] + 16'd1;
                            end
                        end
                        next_seq[layer] = seq + 16'd1;
                    end else begin
                        found = 0;
                        best = 0;
                        best_d = '0;
                        for (k = 0; k < NPL; k++) begin
                            if (gap_held[base+k] && gap_seq[base+k] == seq) begin
                                diff = gap_deadline[base+k] - now;
                                if (!found || diff > best_d) begin
                                    found = 1;
                                    best = base + k;
                                    best_d = diff;
                                end
                            end
                        end
                        if (found) begin
                            gap_held[best] = 0;
                            if (late_total > 0) late_total--;
                            late_down();
                        end
                    end
                end
                if (sp && int'(layer) == int'(joined) - 1 &&
                    losses_since <= int'(losses_ok) && lates_since <= int'(lates_ok)) begin
                    r.join_req = 1;
                    losses_since = 0;
                    lates_since = 0;
                end
            end
        end
        r.losses = loss_total[5:0];
        r.lates = late_total[7:0];
        return r;
    endfunction

    task automatic compare(string what, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_verdict e;
        if (!i_rst_n) begin
            restart();
            expected_results.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_LATE_TIMEOUT: timeout_ms = i_cfg_data;
                    CFG_DEAF_PERIOD:  deaf_ms = i_cfg_data;
                    CFG_LOSSES_ACC:   losses_ok = i_cfg_data;
                    CFG_LATES_ACC:    lates_ok = i_cfg_data;
                    CFG_LOSS_LIMIT:   limit = i_cfg_data[5:0];
                    CFG_LOSS_WINDOW:  window_pkts = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result word with nothing expected, actual status %0d",
                             $time, i_status);
                    o_errors++;
                end else begin
                    e = expected_results.pop_front();
                    compare("status", e.status, i_status);
                    compare("join_request", e.join_req, i_join_request);
                    compare("drop_request", e.drop_req, i_drop_request);
                    compare("losses_in_window", e.losses, i_losses_in_window);
                    compare("lates_pending", e.lates, i_lates_pending);
                    compare("late_overflow", e.ovf, i_late_overflow);
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(predict_header(i_check_byte, i_layer_index,
                    i_seq_number, i_sync_point, i_layers_joined, i_now_ms));
        end
        o_pending = expected_results.size();
    end

endmodule

@@ sim/layered_receiver_congestion_tracker_core_tb.sv @@
`timescale 1ns / 100ps

module layered_receiver_congestion_tracker_core_tb;
    import lrct_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic        i_clk, i_rst_n, i_in_valid, i_out_stall, i_sync_point, i_cfg_we;
    logic [7:0]  i_check_byte, i_layer_index;
    logic [15:0] i_seq_number, i_cfg_data;
    logic [3:0]  i_layers_joined;
    logic [31:0] i_now_ms;
    logic [2:0]  i_cfg_idx;
    logic        o_in_stall, o_out_valid, o_join_request, o_drop_request, o_late_overflow;
    logic [1:0]  o_status;
    logic [5:0]  o_losses_in_window;
    logic [7:0]  o_lates_pending;
    int          pending, errors, idle_cycles, burst_left;
    logic [31:0] clock_ms;
    logic [15:0] next_seq [8];
    int          joined;

    layered_receiver_congestion_tracker_core dut (.*);

    lrct_header_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_check_byte(i_check_byte), .i_layer_index(i_layer_index),
        .i_seq_number(i_seq_number), .i_sync_point(i_sync_point),
        .i_layers_joined(i_layers_joined), .i_now_ms(i_now_ms),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall), .i_status(o_status),
        .i_join_request(o_join_request), .i_drop_request(o_drop_request),
        .i_losses_in_window(o_losses_in_window), .i_lates_pending(o_lates_pending),
        .i_late_overflow(o_late_overflow), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .o_pending(pending), .o_errors(errors)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int mode, len;
        i_out_stall = 0;
        forever begin
            mode = $urandom_range(0, 3);
            len = $urandom_range(5, 60);
            repeat (len) begin
                @(negedge i_clk);
                case (mode)
                    0: i_out_stall = 0;
                    1: i_out_stall = ($urandom_range(0, 3) == 0);
                    2: i_out_stall = 1'($urandom_range(0, 1));
                    default: i_out_stall = ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // Presents one header word and holds it until taken; called at a falling edge.
    task automatic send_word(logic [7:0] chk, logic [7:0] layer, logic [15:0] seq,
                             logic sp, logic [3:0] nj, logic [31:0] now);
        int gap;
        i_check_byte = chk;
        i_layer_index = layer;
        i_seq_number = seq;
        i_sync_point = sp;
        i_layers_joined = nj;
        i_now_ms = now;
        i_in_valid = 1;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid = 0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
    endtask

    task automatic good_word(int layer, logic [15:0] seq, logic sp);
        send_word(CHECK_VALUE, layer[7:0], seq, sp, joined[3:0], clock_ms);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        i_cfg_we = 1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    task automatic wait_drained();
        i_in_valid = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic random_word();
        int r, layer, kind;
        logic [15:0] seq;
        logic sp;
        r = $urandom_range(0, 99);
        if (r < 4) clock_ms = clock_ms + $urandom_range(200, 3000);
        else if (r == 4) clock_ms = clock_ms + $urandom_range(20000, 80000);
        else clock_ms = clock_ms + $urandom_range(0, 40);
        if ($urandom_range(0, 19) == 0) joined = $urandom_range(1, 8);
        kind = $urandom_range(0, 99);
        if (kind < 3) begin
            send_word(8'($urandom_range(0, 255) ^ 8'h01), 8'($urandom_range(0, joined - 1)),
                      16'($urandom), 1'($urandom_range(0, 1)), joined[3:0], clock_ms);
        end else if (kind < 6) begin
            send_word(CHECK_VALUE, 8'($urandom_range(joined, 255)), 16'($urandom),
                      1'($urandom_range(0, 1)), joined[3:0], clock_ms);
        end else if (kind < 8) begin
            send_word(CHECK_VALUE, 8'($urandom_range(0, 255)), 16'($urandom),
                      1'($urandom_range(0, 1)),
                      ($urandom_range(0, 1) != 0) ? 4'd0 : 4'($urandom_range(9, 15)),
                      clock_ms);
        end else begin
            layer = $urandom_range(0, joined - 1);
            r = $urandom_range(0, 99);
            if (r < 68) seq = next_seq[layer];
            else if (r < 80) seq = 16'(next_seq[layer] + $urandom_range(1, 6));
            else if (r < 82) seq = 16'(next_seq[layer] + $urandom_range(17, 40));
            else if (r < 96) seq = 16'(next_seq[layer] - $urandom_range(1, 8));
            else seq = 16'($urandom);
            if (r < 82 || r >= 96) next_seq[layer] = seq + 16'd1;
            sp = (layer == joined - 1) ? ($urandom_range(0, 2) == 0)
                                       : ($urandom_range(0, 9) == 0);
            good_word(layer, seq, sp);
        end
    endtask

    initial begin
        logic [15:0] cfg_set [6];
        i_rst_n = 0;
        i_in_valid = 0;
        i_cfg_we = 0;
        i_cfg_idx = CFG_LATE_TIMEOUT;
        i_cfg_data = '0;
        i_check_byte = '0;
        i_layer_index = '0;
        i_seq_number = '0;
        i_sync_point = 0;
        i_layers_joined = '0;
        i_now_ms = '0;
        burst_left = 1;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // Directed words: sequence and time wrap, late arrival, bad headers,
        // late store overflow, expiry into losses, drop and deaf period.
        clock_ms = 32'hFFFF_FF00;
        joined = 2;
        good_word(0, 16'hFFFE, 0);
        good_word(0, 16'hFFFF, 0);
        good_word(0, 16'h0002, 0);
        good_word(0, 16'h0000, 0);
        good_word(0, 16'h8000, 0);
        send_word(8'h00, 8'd0, 16'h0003, 0, 4'd2, clock_ms);
        send_word(8'hAA, 8'd0, 16'h0003, 1, 4'd2, clock_ms);
        send_word(8'hFF, 8'd0, 16'h0003, 0, 4'd2, clock_ms);
        send_word(CHECK_VALUE, 8'hFF, 16'h0003, 0, 4'd2, clock_ms);
        send_word(CHECK_VALUE, 8'd0, 16'h0003, 0, 4'd0, clock_ms);
        send_word(CHECK_VALUE, 8'd1, 16'h0003, 1, 4'd15, clock_ms);
        good_word(1, 16'h1000, 1);
        good_word(1, 16'h1001, 1);
        good_word(1, 16'h1028, 0);
        joined = 8;
        good_word(7, 16'hFFFF, 1);
        good_word(7, 16'h0000, 1);
        clock_ms = clock_ms + 600;
        good_word(0, 16'h0003, 0);
        good_word(1, 16'h1029, 0);
        clock_ms = clock_ms + 100;
        good_word(0, 16'h0004, 0);
        clock_ms = clock_ms + 10000;
        good_word(0, 16'h0005, 1);
        good_word(7, 16'h0001, 1);
        for (int l = 0; l < 8; l++) next_seq[l] = 16'($urandom);
        wait_drained();

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: cfg_set = '{16'd1, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1};
                1: cfg_set = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd32, 16'hFFFF};
                2: cfg_set = '{16'd300, 16'd500, 16'd4, 16'd8, 16'd6, 16'd0};
                3: cfg_set = '{LATE_TIMEOUT_RST, DEAF_PERIOD_RST, LOSSES_ACC_RST,
                               LATES_ACC_RST, 16'(LOSS_LIMIT_RST), LOSS_WINDOW_RST};
                default: cfg_set = '{16'($urandom_range(1, 2000)),
                                     16'($urandom_range(0, 3000)),
                                     16'($urandom_range(0, 20)), 16'($urandom_range(0, 20)),
                                     16'($urandom_range(1, 32)),
                                     16'($urandom_range(1, 300))};
            endcase
            write_reg(CFG_LATE_TIMEOUT, cfg_set[0]);
            write_reg(CFG_DEAF_PERIOD, cfg_set[1]);
            write_reg(CFG_LOSSES_ACC, cfg_set[2]);
            write_reg(CFG_LATES_ACC, cfg_set[3]);
            write_reg(CFG_LOSS_LIMIT, cfg_set[4]);
            write_reg(CFG_LOSS_WINDOW, cfg_set[5]);
            repeat (110) random_word();
            wait_drained();
        end

        repeat (20) @(negedge i_clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/lrct_pkg.sv
hdl/lrct_late_mem.sv
hdl/layered_receiver_congestion_tracker_core.sv
sim/lrct_header_checker.sv
sim/layered_receiver_congestion_tracker_core_tb.sv
